[hdl/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// dfr_pkg: shared constants and types of the delayed feedback reservoir
// Widths, fixed-point constants and the divider control/status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int NODE_COUNT = 50;
  localparam int IDX_W      = $clog2(NODE_COUNT);

  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 16;
  localparam int NODE_W   = 16;
  localparam int SUM_W    = 22;
  localparam int CFG_W    = 1;

  localparam logic [CFG_W-1:0] CFG_INPUT_GAIN    = 1'b0;
  localparam logic [CFG_W-1:0] CFG_FEEDBACK_GAIN = 1'b1;

  localparam logic [GAIN_W-1:0] INPUT_GAIN_RST    = 16'd32768;
  localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'd26214;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 54;

  // Shared divider widths: dividend, divisor and quotient, and the bit counter.
  localparam int DIVD_W = 37;
  localparam int DIVS_W = 35;
  localparam int CNT_W  = 6;

  localparam int U_DIV_SHIFT   = 12;        // 4095 = 2^12 - 1
  localparam int U_BIAS        = 2047;
  localparam int RECIP10       = 838861;    // ceil(2^23 / 10)
  localparam int RECIP10_SHIFT = 23;
  localparam int RECIP5        = 13421773;  // ceil(2^26 / 5), exact below 2^26
  localparam int RECIP5_SHIFT  = 26;
  localparam int DEN_LO_W      = 19;        // low part of the split /5
  localparam int MG_OFFSET     = 52429;
  localparam int ROUND_HALF    = 32768;

  typedef struct packed {
    logic start;
    logic wide;   // 35 quotient bits when set, 17 otherwise
  } dfr_div_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;    // quotient does not fit the selected width
  } dfr_div_sts_t;

endpackage

[hdl/dfr_mul.sv]
// ----------------------------------------------------------------------------
// dfr_mul: shared unsigned multiplier
// One 25 x 25 bit product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_mul
  import dfr_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

[hdl/dfr_div.sv]
// ----------------------------------------------------------------------------
// dfr_div: shared restoring divider
// One quotient bit per cycle, 35 or 17 bits per division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_div
  import dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dfr_div_ctl_t      ctl,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output dfr_div_sts_t      sts,
  output logic [DIVS_W-1:0] quotient
);

  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] sh_r, sh_nxt;
  logic [DIVS_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   rem0;

  assign trial = {rem_r, sh_r[DIVD_W-1]};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    rem0     = '0;
    if (ctl.start) begin
      if (ctl.wide) begin
        rem0    = (DIVS_W+1)'(dividend >> DIVS_W);
        sh_nxt  = dividend << (DIVD_W - DIVS_W);
        cnt_nxt = CNT_W'(DIVS_W);
      end else begin
        rem0    = (DIVS_W+1)'(dividend >> 17);
        sh_nxt  = dividend << (DIVD_W - 17);
        cnt_nxt = CNT_W'(17);
      end
      ovf_nxt  = rem0 >= (DIVS_W+1)'(divisor);
      rem_nxt  = rem0[DIVS_W-1:0];
      dsr_nxt  = divisor;
      quo_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= (DIVS_W+1)'(dsr_r)) begin
        rem_nxt = DIVS_W'(trial - (DIVS_W+1)'(dsr_r));
        quo_nxt = {quo_r[DIVS_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVS_W-2:0], 1'b0};
      end
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    ovf_r <= ovf_nxt;
  end

  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign quotient = quo_r;

endmodule

[hdl/delayed_feedback_reservoir.sv]
// ----------------------------------------------------------------------------
// delayed_feedback_reservoir: Mackey-Glass delayed feedback reservoir
// Sequencer, node memory and sum around a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage: a 12-bit converter word enters on the in_ channel (valid/ready).
// The block scales it to the unit range, then visits every node in turn,
// mixing the scaled input with the node's value from the previous word and
// passing it through the Mackey-Glass map. The new node values are stored,
// and their saturated sum leaves as one word on the out_ channel.
// The input is scaled as it is taken and then multiplied by its gain; each
// node then needs a fetch, nine multiplier passes and the 17-step output
// division, and that division takes most of the time spent on a word.
// The block takes one word at a time; in_ready is high only between words.
// The finished sum sits in an output register, so a new word is taken while
// the receiver stalls; the next sum then waits until that register is free.
// Reset clears the node values (through per-node valid bits), restores the
// gain registers to 0.5 and 0.4 and empties the output register.
// Gains are to be written through cfg_ only while the block is idle; unchecked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delayed_feedback_reservoir
  import dfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SUM_W-1:0]    out_reservoir_sum,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_addr,
  input  logic [GAIN_W-1:0]   cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_AMUL, ST_ARES, ST_RD, ST_BMUL, ST_TMUL, ST_T2, ST_T4,
    ST_T8, ST_T10L, ST_T10H, ST_DEN, ST_DQH, ST_DQL, ST_YDIV, ST_OUT
  } state_t;

  state_t state_r;

  logic [GAIN_W-1:0] gamma_r;
  logic [GAIN_W-1:0] eta_r;
  logic [16:0]       u_r;
  logic [NODE_W-1:0] a_r;
  logic [16:0]       m_r;
  logic [20:0]       t2_r;
  logic [32:0]       t8_r;
  logic [45:0]       acc_r;
  logic [DIVD_W-DEN_LO_W-1:0] dxh_r;
  logic [DEN_LO_W-1:0]        dxl_r;
  logic [15:0]       qh_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SUM_W-1:0]  sum_r;
  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;

  // Node memory; an entry not written since reset reads as zero.
  logic [NODE_W-1:0]     node_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] node_vld_r;
  logic [NODE_W-1:0]     rd_data_r;
  logic                  rd_vld_r;
  logic [NODE_W-1:0]     prev;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] mul_rnd;

  dfr_div_ctl_t      div_ctl;
  dfr_div_sts_t      div_sts;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic [DIVS_W-1:0] div_q;

  logic [16:0]       ux_c;
  logic [4:0]        uq_c;
  logic [16:0]       u_c;
  logic [NODE_W-1:0] b_c;
  logic [16:0]       m_c;
  logic [21:0]       v_c;
  logic [ACC_W-1:0]  t10_prod;
  logic [ACC_W-1:0]  t10_rnd;
  logic [DIVD_W-1:0] dx_c;
  logic [15:0]       qh_c;
  logic [2:0]        rh_c;
  logic [DEN_LO_W-1:0] ql_c;
  logic [DIVS_W-1:0] den_c;
  logic [NODE_W-1:0] y_c;
  logic [SUM_W:0]    sum_add;

  // Scaling by 65536/4095: sample*65536 = 4095*16*sample + 16*sample, so the
  // quotient is 16*sample plus (16*sample + 2047) / 4095, which is at most 16.
  // That small quotient uses the 2^12 - 1 identity instead of a divider.
  assign ux_c    = {1'b0, in_sample, 4'b0} + 17'(U_BIAS);
  assign uq_c    = 5'((ux_c + (ux_c >> U_DIV_SHIFT) + 17'd1) >> U_DIV_SHIFT);
  assign u_c     = {1'b0, in_sample, 4'b0} + 17'(uq_c);

  assign prev    = rd_vld_r ? rd_data_r : '0;
  assign mul_rnd = mul_p + PROD_W'(ROUND_HALF);
  assign b_c     = mul_rnd[16 +: NODE_W];
  assign m_c     = 17'(a_r) + 17'(b_c);
  // m * 21 + 5, the numerator of the scaling by 2.1 with rounding.
  assign v_c     = (22'(m_c) << 4) + (22'(m_c) << 2) + 22'(m_c) + 22'd5;
  assign t10_prod = ACC_W'(acc_r) + (ACC_W'(mul_p) << MUL_W);
  assign t10_rnd  = t10_prod + ACC_W'(ROUND_HALF);
  // (t10 + 2) / 5 is split in a high and a low part, each divided by a
  // reciprocal multiplication; the high remainder carries into the low part.
  assign dx_c     = t10_rnd[16 +: DIVD_W] + DIVD_W'(2);
  assign qh_c     = mul_p[RECIP5_SHIFT +: 16];
  assign rh_c     = 3'(dxh_r - ((DIVD_W-DEN_LO_W)'(qh_c) << 2)
                    - (DIVD_W-DEN_LO_W)'(qh_c));
  assign ql_c     = mul_p[RECIP5_SHIFT +: DEN_LO_W];
  assign den_c    = DIVS_W'(MG_OFFSET) + DIVS_W'({qh_r, ql_c});
  // A node output at or above one saturates.
  assign y_c      = (div_sts.ovf || (div_q > DIVS_W'(16'hFFFF))) ? '1 : div_q[NODE_W-1:0];
  assign sum_add  = (SUM_W+1)'(sum_r) + (SUM_W+1)'(y_c);

  dfr_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  dfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_AMUL: begin
        mul_a = MUL_W'(gamma_r);
        mul_b = MUL_W'(u_r);
      end
      ST_BMUL: begin
        mul_a = MUL_W'(eta_r);
        mul_b = MUL_W'(prev);
      end
      ST_TMUL: begin
        mul_a = MUL_W'(v_c);
        mul_b = MUL_W'(RECIP10);
      end
      ST_T2: begin
        mul_a = MUL_W'(mul_p >> RECIP10_SHIFT);
        mul_b = MUL_W'(mul_p >> RECIP10_SHIFT);
      end
      ST_T4: begin
        mul_a = MUL_W'(mul_rnd[16 +: 21]);
        mul_b = MUL_W'(mul_rnd[16 +: 21]);
      end
      ST_T8: begin
        mul_a = mul_rnd[16 +: MUL_W];
        mul_b = mul_rnd[16 +: MUL_W];
      end
      ST_T10L: begin
        mul_a = mul_rnd[16 +: MUL_W];
        mul_b = MUL_W'(t2_r);
      end
      ST_T10H: begin
        mul_a = MUL_W'(t8_r[32:MUL_W]);
        mul_b = MUL_W'(t2_r);
      end
      ST_DEN: begin
        mul_a = MUL_W'(dx_c[DIVD_W-1:DEN_LO_W]);
        mul_b = MUL_W'(RECIP5);
      end
      ST_DQH: begin
        mul_a = MUL_W'({rh_c, dxl_r});
        mul_b = MUL_W'(RECIP5);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider request: the node output, once its denominator is known.
  always_comb begin
    div_ctl      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_r)
      ST_DQL: begin
        div_ctl.start = 1'b1;
        div_dividend  = (DIVD_W'(m_r) << 17) + DIVD_W'(den_c >> 1);
        div_divisor   = den_c;
      end
      default: begin
        div_ctl      = '0;
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      rd_data_r <= node_mem[idx_r];
    end
    if (state_r == ST_YDIV && div_sts.done) begin
      node_mem[idx_r] <= y_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gamma_r     <= INPUT_GAIN_RST;
      eta_r       <= FEEDBACK_GAIN_RST;
      node_vld_r  <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_INPUT_GAIN:    gamma_r <= cfg_wdata;
          CFG_FEEDBACK_GAIN: eta_r   <= cfg_wdata;
          default:           gamma_r <= gamma_r;
        endcase
      end
      // In ST_OUT the output register is refilled in the same cycle instead.
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sum_r   <= '0;
            u_r     <= u_c;
            state_r <= ST_AMUL;
          end
        end
        ST_AMUL: state_r <= ST_ARES;
        ST_ARES: begin
          a_r     <= mul_rnd[16 +: NODE_W];
          idx_r   <= '0;
          state_r <= ST_RD;
        end
        ST_RD: begin
          rd_vld_r <= node_vld_r[idx_r];
          state_r  <= ST_BMUL;
        end
        ST_BMUL: state_r <= ST_TMUL;
        ST_TMUL: begin
          m_r     <= m_c;
          state_r <= ST_T2;
        end
        ST_T2: state_r <= ST_T4;
        ST_T4: begin
          t2_r    <= mul_rnd[16 +: 21];
          state_r <= ST_T8;
        end
        ST_T8: state_r <= ST_T10L;
        ST_T10L: begin
          t8_r    <= mul_rnd[16 +: 33];
          state_r <= ST_T10H;
        end
        ST_T10H: begin
          acc_r   <= mul_p[45:0];
          state_r <= ST_DEN;
        end
        ST_DEN: begin
          dxh_r   <= dx_c[DIVD_W-1:DEN_LO_W];
          dxl_r   <= dx_c[DEN_LO_W-1:0];
          state_r <= ST_DQH;
        end
        ST_DQH: begin
          qh_r    <= qh_c;
          state_r <= ST_DQL;
        end
        ST_DQL: state_r <= ST_YDIV;
        ST_YDIV: begin
          if (div_sts.done) begin
            node_vld_r[idx_r] <= 1'b1;
            sum_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (idx_r == IDX_W'(NODE_COUNT - 1)) begin
              state_r <= ST_OUT;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= ST_RD;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= sum_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_reservoir_sum = out_sum_r;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the delayed feedback reservoir
// Drives converter words under several gain settings and idle patterns, and
// compares each output sum with a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The scoreboard keeps its own copy of the gains and the node values, and
// computes the expected reservoir sum for every accepted word.
class reservoir_scoreboard;
  logic [dfr_pkg::GAIN_W-1:0] gamma;
  logic [dfr_pkg::GAIN_W-1:0] eta;
  logic [dfr_pkg::NODE_W-1:0] nodes[dfr_pkg::NODE_COUNT];
  logic [dfr_pkg::SUM_W-1:0]  sum_queue[$];
  int                         errors;

  function new();
    gamma  = dfr_pkg::INPUT_GAIN_RST;
    eta    = dfr_pkg::FEEDBACK_GAIN_RST;
    errors = 0;
    foreach (nodes[i]) nodes[i] = '0;
  endfunction

  function void set_gain(logic [dfr_pkg::CFG_W-1:0] addr, logic [dfr_pkg::GAIN_W-1:0] val);
    if (addr == dfr_pkg::CFG_INPUT_GAIN) gamma = val;
    else if (addr == dfr_pkg::CFG_FEEDBACK_GAIN) eta = val;
  endfunction

  static function longint unsigned fx_mul(longint unsigned x, longint unsigned y);
    return (x * y + 64'd32768) >> 16;
  endfunction

  // Mackey-Glass map 2m / (0.8 + 0.2 * (2.1m)^10) in Q.16, clamped below one.
  static function logic [15:0] mg_node_map(longint unsigned m);
    longint unsigned t, t2, t4, t8, t10, den, y;
    t   = (m * 21 + 5) / 10;
    t2  = fx_mul(t, t);
    t4  = fx_mul(t2, t2);
    t8  = fx_mul(t4, t4);
    t10 = fx_mul(t8, t2);
    den = 64'd52429 + (t10 * 2 + 5) / 10;
    y   = (((2 * m) << 16) + den / 2) / den;
    if (y > 65535) y = 65535;
    return y[15:0];
  endfunction

  function void note_word(logic [dfr_pkg::SAMPLE_W-1:0] sample);
    longint unsigned u, a, b, total;
    logic [15:0] y;
    u = (longint'(sample) * 65536 + 2047) / 4095;
    a = fx_mul(gamma, u);
    total = 0;
    for (int i = 0; i < dfr_pkg::NODE_COUNT; i++) begin
      b = fx_mul(eta, nodes[i]);
      y = mg_node_map(a + b);
      nodes[i] = y;
      total += y;
    end
    if (total > 4194303) total = 4194303;
    sum_queue.push_back(total[dfr_pkg::SUM_W-1:0]);
  endfunction

  function void check_sum(logic [dfr_pkg::SUM_W-1:0] got);
    logic [dfr_pkg::SUM_W-1:0] want;
    if (sum_queue.size() == 0) begin
      $error("reservoir_sum: unexpected word, actual %0d", got);
      errors++;
      return;
    end
    want = sum_queue.pop_front();
    if (got !== want) begin
      $error("reservoir_sum: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction
endclass

module testbench;
  import dfr_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SUM_W-1:0]    out_reservoir_sum;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_addr = '0;
  logic [GAIN_W-1:0]   cfg_wdata = '0;

  // Idle pattern: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly.
  int                  idle_mode = 0;
  reservoir_scoreboard sb = new();

  always #2 clk = ~clk;

  delayed_feedback_reservoir u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reservoir_sum(out_reservoir_sum),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  // The receiver checks each accepted word against the oldest expected sum and
  // picks its ready for the next cycle from the current idle pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_sum(out_reservoir_sum);
    case (idle_mode)
      2: begin
        out_ready <= ($urandom_range(99) >= 73);
      end
      3: begin
        out_ready <= ($urandom_range(99) >= 17);
      end
      default: begin
        out_ready <= 1'b1;
      end
    endcase
  end

  // Offers one word; the sender may first idle for a random number of cycles.
  // Valid stays high after acceptance so back-to-back words need no dip.
  task automatic send_word(input logic [SAMPLE_W-1:0] sample);
    int pct;
    pct = (idle_mode == 1) ? 73 : (idle_mode == 3) ? 17 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= sample;
    do @(posedge clk); while (!in_ready);
    sb.note_word(sample);
  endtask

  // Lets the block drain completely before a gain is touched.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.sum_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] gamma, input logic [GAIN_W-1:0] eta);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_INPUT_GAIN;
    cfg_wdata <= gamma;
    @(posedge clk);
    cfg_addr  <= CFG_FEEDBACK_GAIN;
    cfg_wdata <= eta;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_gain(CFG_INPUT_GAIN, gamma);
    sb.set_gain(CFG_FEEDBACK_GAIN, eta);
    @(posedge clk);
  endtask

  // A random word, biased now and then toward the ends of the converter range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 12'(4095 - $urandom_range(40));
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    logic [GAIN_W-1:0] gammas[7];
    logic [GAIN_W-1:0] etas[7];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset gains: range ends and single bits, so
    // the node values start from zero and then feed back on themselves.
    send_word(12'd0);
    send_word(12'd4095);
    send_word(12'd4095);
    for (int b = 0; b < SAMPLE_W; b++) send_word(12'(1 << b));
    send_word(12'd2048);
    send_word(12'd0);
    drain();

    // Full gains drive the map input past one.
    write_gains(16'hFFFF, 16'hFFFF);
    for (int k = 0; k < 5; k++) send_word(12'd4095);
    drain();

    // Random phases: each gain setting runs under every idle pattern in turn.
    gammas = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd32768, 16'd0, 16'd0};
    etas   = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd26214, 16'd0, 16'd0};
    for (int p = 0; p < 7; p++) begin
      if (p >= 5) begin
        gammas[p] = 16'($urandom_range(65535));
        etas[p]   = 16'($urandom_range(65535));
      end
      write_gains(gammas[p], etas[p]);
      for (int n = 0; n < 115; n++) begin
        idle_mode = (n / 20) % 4;
        if (n % 40 == 39) idle_mode = 0;
        send_word(pick_sample());
      end
      idle_mode = 0;
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.sum_queue.size() == 0) begin
      $display("[delayed_feedback_reservoir] OK");
    end else begin
      $display("[delayed_feedback_reservoir] ERROR");
    end
    $finish;
  end

  // A timeout well beyond the length of the whole run ends a hung simulation.
  initial begin
    #(100_000_000);
    $display("[delayed_feedback_reservoir] ERROR");
    $finish;
  end
endmodule
